// ----- src/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Event codes, thread status codes and the per-level quantum table.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_TICK  = 3'd1;
    localparam logic [2:0] MODE_YIELD = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;
    localparam logic [2:0] MODE_TERM  = 3'd4;
    localparam logic [2:0] MODE_BOOST = 3'd5;
    localparam logic [2:0] MODE_SCAN  = 3'd6;

    localparam logic [2:0] ST_UNQUEUED = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    localparam logic [15:0] THRESH_RESET = 16'd500;

    localparam logic [11:0] QUANTA [64] = '{
        12'd10,   12'd11,   12'd12,   12'd13,   12'd15,   12'd16,   12'd18,   12'd19,
        12'd21,   12'd24,   12'd26,   12'd29,   12'd31,   12'd35,   12'd38,   12'd42,
        12'd46,   12'd51,   12'd56,   12'd61,   12'd67,   12'd74,   12'd81,   12'd90,
        12'd98,   12'd108,  12'd119,  12'd131,  12'd144,  12'd159,  12'd174,  12'd192,
        12'd211,  12'd232,  12'd255,  12'd281,  12'd309,  12'd340,  12'd374,  12'd411,
        12'd453,  12'd498,  12'd548,  12'd602,  12'd663,  12'd729,  12'd802,  12'd882,
        12'd970,  12'd1067, 12'd1174, 12'd1291, 12'd1420, 12'd1562, 12'd1719, 12'd1891,
        12'd2080, 12'd2288, 12'd2516, 12'd2768, 12'd3045, 12'd3349, 12'd3684, 12'd4053
    };

    function automatic logic [11:0] qtab(input logic [5:0] lvl);
        return QUANTA[lvl];
    endfunction

endpackage

// ----- src/mlfq_thread_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// MLFQ thread scheduler
// Sequenced multilevel feedback queue scheduler with linked ready queues
// kept in on-chip memories and a per-thread record memory.
// ----------------------------------------------------------------------------
//  channel | signals                           | content
//  s_axis  | tvalid tready tdata[31:0]         | one scheduling event
//  m_axis  | tvalid tready tdata[15:0]         | one scheduler result
//  cfg     | valid ready data[15:0]            | starvation threshold
//
//  Events run as a state sequence from acceptance to result; each bitmap
//  walk steps through the levels in turn, and a dispatch adds the pop and
//  record update. Boost moves every thread queued at levels 1 and up to
//  level 0 and walks the levels; the starvation scan visits each queued
//  thread at levels 1 and up. One event at a time; the input reopens as the
//  result is posted.
//  Reset is immediate: thread status uses per-slot valid bits, no sweep.
//  A stalled result holds in the output register until it is taken.
module mlfq_thread_scheduler_unit #(
    parameter int LEVELS  = 64,
    parameter int THREADS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0] thread_id[8:3] priority_req[16:9] initial_quantum[28:17]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // current_thread[5:0] core_busy[6] switched[7] preempt_request[8] accepted[9]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import mlfq_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);

    typedef enum logic [33:0] {
        S_IDLE = 34'b1 << 0,  S_DEC  = 34'b1 << 1,  S_LDT  = 34'b1 << 2,
        S_LDT2 = 34'b1 << 3,  S_A1   = 34'b1 << 4,  S_A2   = 34'b1 << 5,
        S_A3   = 34'b1 << 6,  S_T1   = 34'b1 << 7,  S_T2   = 34'b1 << 8,
        S_Y1   = 34'b1 << 9,  S_B1   = 34'b1 << 10, S_D0   = 34'b1 << 11,
        S_D1   = 34'b1 << 12, S_D2   = 34'b1 << 13, S_F0   = 34'b1 << 14,
        S_Q0   = 34'b1 << 15, S_Q1   = 34'b1 << 16, S_Q2   = 34'b1 << 17,
        S_Q3   = 34'b1 << 18, S_P0   = 34'b1 << 19, S_P1   = 34'b1 << 20,
        S_BS1  = 34'b1 << 21, S_BS2  = 34'b1 << 22, S_BS3  = 34'b1 << 23,
        S_BR   = 34'b1 << 24, S_BR1  = 34'b1 << 25, S_SC1  = 34'b1 << 26,
        S_SC2  = 34'b1 << 27, S_SC3  = 34'b1 << 28, S_SC4  = 34'b1 << 29,
        S_SC5  = 34'b1 << 30, S_SC6  = 34'b1 << 31, S_SC7  = 34'b1 << 32,
        S_FIN  = 34'b1 << 33
    } state_t;

    state_t state_reg, ret_reg, pret_reg;

    logic [15:0]        thr_reg;
    logic [LEVELS-1:0]  bm_reg;
    logic [TW-1:0]      run_slot_reg;
    logic               run_v_reg;
    logic [31:0]        tick_reg;

    logic [2:0]         mode_reg;
    logic [5:0]         tid_reg;
    logic [7:0]         preq_reg;
    logic [11:0]        iq_reg;
    logic               was_v_reg;
    logic [TW-1:0]      was_slot_reg;
    logic               acc_reg;
    logic               pre_reg;
    logic               fctx_reg;

    logic [TW-1:0]      t_reg;
    logic [TW-1:0]      p_reg;
    logic [LW-1:0]      l_reg;
    logic [LW-1:0]      bl_reg;
    logic [LW-1:0]      w_lv_reg;
    logic [11:0]        w_sl_reg;
    logic [31:0]        w_ws_reg;
    logic [2:0]         w_st_reg;

    logic [TW-1:0]      tl_sv_reg;
    logic [TW-1:0]      nxt_reg;
    logic [TW-1:0]      kh_reg;
    logic [TW-1:0]      kt_reg;
    logic               kept_reg;
    logic               last_reg;
    logic [TW-1:0]      steps_reg;

    logic               ov_reg;
    logic [15:0]        out_reg;

    logic [THREADS-1:0] vld_reg;

    logic [LW-1:0]      lv_mem [THREADS];
    logic [11:0]        sl_mem [THREADS];
    logic [31:0]        ws_mem [THREADS];
    logic [2:0]         st_mem [THREADS];
    logic [TW-1:0]      lk_mem [THREADS];
    logic [TW-1:0]      hd_mem [LEVELS];
    logic [TW-1:0]      tl_mem [LEVELS];

    logic [LW-1:0]      lv_q;
    logic [11:0]        sl_q;
    logic [31:0]        ws_q;
    logic [2:0]         st_q;
    logic               vld_q;
    logic [TW-1:0]      lk_q;
    logic [TW-1:0]      hd_q;
    logic [TW-1:0]      tl_q;

    logic               rec_we;
    logic [LW-1:0]      rec_lv;
    logic [11:0]        rec_sl;
    logic [31:0]        rec_ws;
    logic [2:0]         rec_st;
    logic               hd_we;
    logic               tl_we;
    logic [LW-1:0]      lvl_wa;
    logic [TW-1:0]      hd_wd;
    logic [TW-1:0]      tl_wd;
    logic               lk_we;
    logic [TW-1:0]      lk_wa;
    logic [TW-1:0]      lk_wd;

    logic               in_fire;
    logic               stale;
    logic [LW-1:0]      sat_lvl;
    logic [LW-1:0]      dem_lvl;
    logic [LW-1:0]      pro_lvl;
    logic               sw;

    function automatic logic [LW-1:0] promote(input logic [LW-1:0] lv,
                                              input logic [11:0] sl);
        logic [11:0] full;
        full = qtab(6'(lv));
        if (sl <= full && (full - sl) < (full >> 1) && lv != '0)
            return lv - 1'b1;
        return lv;
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    assign stale   = (tick_reg - w_ws_reg) > {16'd0, thr_reg};
    assign sat_lvl = ({1'b0, preq_reg} >= 9'(LEVELS)) ? LW'(LEVELS - 1) : LW'(preq_reg);
    assign dem_lvl = (w_lv_reg == LW'(LEVELS - 1)) ? w_lv_reg : w_lv_reg + 1'b1;
    assign pro_lvl = promote(w_lv_reg, w_sl_reg);
    assign sw      = (was_v_reg != run_v_reg) || (run_v_reg && was_slot_reg != run_slot_reg);

    always_comb
    begin
        rec_we = 1'b0;
        rec_lv = w_lv_reg;
        rec_sl = w_sl_reg;
        rec_ws = w_ws_reg;
        rec_st = w_st_reg;
        hd_we  = 1'b0;
        tl_we  = 1'b0;
        lvl_wa = l_reg;
        hd_wd  = t_reg;
        tl_wd  = t_reg;
        lk_we  = 1'b0;
        lk_wa  = tl_q;
        lk_wd  = t_reg;
        case (state_reg)
            S_P0:
            begin
                rec_we = 1'b1;
                rec_lv = l_reg;
                rec_st = ST_READY;
                hd_we  = !bm_reg[l_reg];
                tl_we  = !bm_reg[l_reg];
            end
            S_P1:
            begin
                lk_we = 1'b1;
                tl_we = 1'b1;
            end
            S_Q3:
            begin
                hd_we = 1'b1;
                hd_wd = lk_q;
            end
            S_D2:
            begin
                rec_we = 1'b1;
                rec_st = ST_RUNNING;
            end
            S_T1:
            begin
                rec_we = (w_sl_reg > 12'd1);
                rec_sl = w_sl_reg - 12'd1;
            end
            S_B1:
            begin
                rec_we = 1'b1;
                if (mode_reg == MODE_BLOCK)
                begin
                    rec_lv = pro_lvl;
                    rec_sl = qtab(6'(pro_lvl));
                    rec_st = ST_BLOCKED;
                end
                else
                begin
                    rec_st = ST_ZOMBIE;
                end
            end
            S_BR1:
            begin
                rec_we = (w_lv_reg != '0);
                rec_lv = '0;
                rec_sl = qtab(6'd0);
            end
            S_SC5:
            begin
                lk_we = !stale && kept_reg;
                lk_wa = kt_reg;
                lk_wd = p_reg;
            end
            S_SC7:
            begin
                hd_we  = kept_reg;
                tl_we  = kept_reg;
                lvl_wa = bl_reg;
                hd_wd  = kh_reg;
                tl_wd  = kt_reg;
            end
            default:
            begin
                rec_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            lv_mem[t_reg] <= rec_lv;
            sl_mem[t_reg] <= rec_sl;
            ws_mem[t_reg] <= rec_ws;
            st_mem[t_reg] <= rec_st;
        end
        lv_q  <= lv_mem[t_reg];
        sl_q  <= sl_mem[t_reg];
        ws_q  <= ws_mem[t_reg];
        st_q  <= st_mem[t_reg];
        vld_q <= vld_reg[t_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
            lk_mem[lk_wa] <= lk_wd;
        lk_q <= lk_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
            hd_mem[lvl_wa] <= hd_wd;
        if (tl_we)
            tl_mem[lvl_wa] <= tl_wd;
        hd_q <= hd_mem[l_reg];
        tl_q <= tl_mem[l_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (rec_we)
            vld_reg[t_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESH_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            pret_reg     <= S_IDLE;
            bm_reg       <= '0;
            run_slot_reg <= '0;
            run_v_reg    <= 1'b0;
            tick_reg     <= '0;
            acc_reg      <= 1'b0;
            pre_reg      <= 1'b0;
            fctx_reg     <= 1'b0;
            kept_reg     <= 1'b0;
            last_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_axis_tready && state_reg != S_FIN)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        mode_reg     <= s_axis_tdata[2:0];
                        tid_reg      <= s_axis_tdata[8:3];
                        preq_reg     <= s_axis_tdata[16:9];
                        iq_reg       <= s_axis_tdata[28:17];
                        was_v_reg    <= run_v_reg;
                        was_slot_reg <= run_slot_reg;
                        acc_reg      <= 1'b0;
                        pre_reg      <= 1'b0;
                        state_reg    <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    state_reg <= S_FIN;
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            if ({3'd0, tid_reg} < 9'(THREADS))
                            begin
                                t_reg     <= TW'(tid_reg);
                                ret_reg   <= S_A1;
                                state_reg <= S_LDT;
                            end
                        end
                        MODE_TICK:
                        begin
                            acc_reg  <= 1'b1;
                            tick_reg <= tick_reg + 32'd1;
                            if (!run_v_reg)
                                state_reg <= S_D0;
                            else
                            begin
                                t_reg     <= run_slot_reg;
                                ret_reg   <= S_T1;
                                state_reg <= S_LDT;
                            end
                        end
                        MODE_YIELD:
                        begin
                            if (run_v_reg)
                            begin
                                acc_reg <= 1'b1;
                                if (bm_reg != '0)
                                begin
                                    t_reg     <= run_slot_reg;
                                    ret_reg   <= S_Y1;
                                    state_reg <= S_LDT;
                                end
                            end
                        end
                        MODE_BLOCK, MODE_TERM:
                        begin
                            if (run_v_reg)
                            begin
                                acc_reg   <= 1'b1;
                                t_reg     <= run_slot_reg;
                                ret_reg   <= S_B1;
                                state_reg <= S_LDT;
                            end
                        end
                        MODE_BOOST:
                        begin
                            acc_reg   <= 1'b1;
                            bl_reg    <= LW'(1);
                            state_reg <= S_BS1;
                        end
                        MODE_SCAN:
                        begin
                            acc_reg   <= 1'b1;
                            bl_reg    <= LW'(1);
                            state_reg <= S_SC1;
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_LDT:
                begin
                    state_reg <= S_LDT2;
                end
                S_LDT2:
                begin
                    w_lv_reg  <= lv_q;
                    w_sl_reg  <= sl_q;
                    w_ws_reg  <= ws_q;
                    w_st_reg  <= vld_q ? st_q : ST_UNQUEUED;
                    state_reg <= ret_reg;
                end
                S_A1:
                begin
                    if (w_st_reg == ST_READY || w_st_reg == ST_RUNNING)
                        state_reg <= S_FIN;
                    else
                    begin
                        acc_reg <= 1'b1;
                        if (w_st_reg == ST_BLOCKED)
                        begin
                            l_reg <= w_lv_reg;
                            if (w_sl_reg == '0)
                                w_sl_reg <= qtab(6'(w_lv_reg));
                        end
                        else
                        begin
                            l_reg    <= sat_lvl;
                            w_sl_reg <= (iq_reg != '0) ? iq_reg : qtab(6'(sat_lvl));
                        end
                        w_ws_reg  <= tick_reg;
                        ret_reg   <= S_A2;
                        state_reg <= S_P0;
                    end
                end
                S_A2:
                begin
                    if (!run_v_reg)
                    begin
                        pre_reg   <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        t_reg     <= run_slot_reg;
                        ret_reg   <= S_A3;
                        state_reg <= S_LDT;
                    end
                end
                S_A3:
                begin
                    pre_reg   <= (l_reg < w_lv_reg);
                    state_reg <= S_FIN;
                end
                S_T1:
                begin
                    if (w_sl_reg <= 12'd1)
                    begin
                        l_reg     <= dem_lvl;
                        w_sl_reg  <= qtab(6'(dem_lvl));
                        w_ws_reg  <= tick_reg;
                        ret_reg   <= S_D0;
                        state_reg <= S_P0;
                    end
                    else
                    begin
                        w_sl_reg <= w_sl_reg - 12'd1;
                        if (bm_reg != '0)
                        begin
                            l_reg     <= '0;
                            fctx_reg  <= 1'b1;
                            state_reg <= S_F0;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_T2:
                begin
                    if (l_reg < w_lv_reg)
                    begin
                        w_ws_reg  <= tick_reg;
                        l_reg     <= w_lv_reg;
                        ret_reg   <= S_D0;
                        state_reg <= S_P0;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_Y1:
                begin
                    l_reg     <= pro_lvl;
                    w_ws_reg  <= tick_reg;
                    ret_reg   <= S_D0;
                    state_reg <= S_P0;
                end
                S_B1:
                begin
                    state_reg <= S_D0;
                end
                S_D0:
                begin
                    if (bm_reg == '0)
                    begin
                        run_v_reg <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        l_reg     <= '0;
                        fctx_reg  <= 1'b0;
                        state_reg <= S_F0;
                    end
                end
                S_F0:
                begin
                    if (bm_reg[l_reg] || l_reg == LW'(LEVELS - 1))
                    begin
                        if (fctx_reg)
                            state_reg <= S_T2;
                        else
                        begin
                            pret_reg  <= S_D1;
                            state_reg <= S_Q0;
                        end
                    end
                    else
                        l_reg <= l_reg + 1'b1;
                end
                S_Q0:
                begin
                    state_reg <= S_Q1;
                end
                S_Q1:
                begin
                    p_reg <= hd_q;
                    if (hd_q == tl_q)
                    begin
                        bm_reg[l_reg] <= 1'b0;
                        state_reg     <= pret_reg;
                    end
                    else
                        state_reg <= S_Q2;
                end
                S_Q2:
                begin
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    state_reg <= pret_reg;
                end
                S_D1:
                begin
                    t_reg        <= p_reg;
                    run_slot_reg <= p_reg;
                    run_v_reg    <= 1'b1;
                    ret_reg      <= S_D2;
                    state_reg    <= S_LDT;
                end
                S_D2:
                begin
                    state_reg <= S_FIN;
                end
                S_P0:
                begin
                    if (bm_reg[l_reg])
                        state_reg <= S_P1;
                    else
                    begin
                        bm_reg[l_reg] <= 1'b1;
                        state_reg     <= ret_reg;
                    end
                end
                S_P1:
                begin
                    state_reg <= ret_reg;
                end
                S_BS1:
                begin
                    if (bm_reg[bl_reg])
                    begin
                        l_reg     <= bl_reg;
                        pret_reg  <= S_BS2;
                        state_reg <= S_Q0;
                    end
                    else if (bl_reg == LW'(LEVELS - 1))
                        state_reg <= S_BR;
                    else
                        bl_reg <= bl_reg + 1'b1;
                end
                S_BS2:
                begin
                    t_reg     <= p_reg;
                    ret_reg   <= S_BS3;
                    state_reg <= S_LDT;
                end
                S_BS3:
                begin
                    w_sl_reg  <= qtab(6'd0);
                    l_reg     <= '0;
                    ret_reg   <= S_BS1;
                    state_reg <= S_P0;
                end
                S_BR:
                begin
                    if (run_v_reg)
                    begin
                        t_reg     <= run_slot_reg;
                        ret_reg   <= S_BR1;
                        state_reg <= S_LDT;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_BR1:
                begin
                    state_reg <= S_FIN;
                end
                S_SC1:
                begin
                    if (bm_reg[bl_reg])
                    begin
                        l_reg     <= bl_reg;
                        kept_reg  <= 1'b0;
                        steps_reg <= '0;
                        state_reg <= S_SC2;
                    end
                    else if (bl_reg == LW'(LEVELS - 1))
                        state_reg <= S_FIN;
                    else
                        bl_reg <= bl_reg + 1'b1;
                end
                S_SC2:
                begin
                    state_reg <= S_SC3;
                end
                S_SC3:
                begin
                    p_reg     <= hd_q;
                    tl_sv_reg <= tl_q;
                    state_reg <= S_SC4;
                end
                S_SC4:
                begin
                    t_reg     <= p_reg;
                    ret_reg   <= S_SC5;
                    state_reg <= S_LDT;
                end
                S_SC5:
                begin
                    last_reg <= (p_reg == tl_sv_reg);
                    nxt_reg  <= lk_q;
                    if (stale)
                    begin
                        w_ws_reg  <= tick_reg;
                        l_reg     <= '0;
                        ret_reg   <= S_SC6;
                        state_reg <= S_P0;
                    end
                    else
                    begin
                        if (!kept_reg)
                            kh_reg <= p_reg;
                        kt_reg    <= p_reg;
                        kept_reg  <= 1'b1;
                        state_reg <= S_SC6;
                    end
                end
                S_SC6:
                begin
                    if (last_reg || steps_reg == TW'(THREADS - 1)
                        || {1'b0, nxt_reg} >= (TW + 1)'(THREADS))
                        state_reg <= S_SC7;
                    else
                    begin
                        p_reg     <= nxt_reg;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_SC4;
                    end
                end
                S_SC7:
                begin
                    if (!kept_reg)
                        bm_reg[bl_reg] <= 1'b0;
                    if (bl_reg == LW'(LEVELS - 1))
                        state_reg <= S_FIN;
                    else
                    begin
                        bl_reg    <= bl_reg + 1'b1;
                        state_reg <= S_SC1;
                    end
                end
                S_FIN:
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_reg    <= 1'b1;
                        out_reg   <= {6'd0, acc_reg, pre_reg, sw, run_v_reg,
                                      run_v_reg ? 6'(run_slot_reg) : 6'd0};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_ignored_no_switch : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !acc_reg) |-> !sw)
        else $error("ignored event changed the running thread");

    a_preempt_accepted : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && pre_reg) |-> (acc_reg && mode_reg == MODE_ADD))
        else $error("preempt request without an accepted add");

    a_find_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F0) |-> (bm_reg != '0))
        else $error("level search on an empty bitmap");

    a_result_after_fin : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!ov_reg || m_axis_tready)) |=> (ov_reg && state_reg == S_IDLE))
        else $error("result not posted after event completion");

endmodule
